[hdl/cbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_pkg: shared constants for the circular budget prefix search
// Field widths, request codes and reset values used by the interfaces and the
// top level.
// ----------------------------------------------------------------------------
package cbps_pkg;

    localparam int MAX_ITEMS_DEF = 16384;

    localparam int REQ_TYPE_W = 1;
    localparam int COST_W     = 16;
    localparam int POS_W      = 15;
    localparam int BUDGET_W   = 31;
    localparam int COUNT_W    = 15;
    localparam int SUM_W      = 30;

    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 1'b1;

    localparam logic [COUNT_W-1:0] ITEM_COUNT_RST = 15'd16384;
    localparam logic [SUM_W-1:0]   SUM_MAX        = 30'h3FFF_FFFF;

endpackage

[hdl/cbps_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_req_if: request channel
// Carries load and query words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbps_req_if;
    logic                               valid;
    logic                               ready;
    logic [cbps_pkg::REQ_TYPE_W-1:0]    req_type;
    logic [cbps_pkg::COST_W-1:0]        item_cost;
    logic [cbps_pkg::POS_W-1:0]         start_pos;
    logic [cbps_pkg::BUDGET_W-1:0]      budget;

    modport source (output valid, output req_type, output item_cost,
                    output start_pos, output budget, input ready);
    modport sink   (input valid, input req_type, input item_cost,
                    input start_pos, input budget, output ready);
endinterface

[hdl/cbps_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_rsp_if: result channel
// Carries one affordable count word per query with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbps_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cbps_pkg::COUNT_W-1:0]   affordable_count;

    modport source (output valid, output affordable_count, input ready);
    modport sink   (input valid, input affordable_count, output ready);
endinterface

[hdl/circular_budget_prefix_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_budget_prefix_search: prefix sums over a circular list
// Stores running prefix sums of loaded costs and answers budget queries by a
// binary search over the stored sums, with a separate wrap-around case.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  i_req     in    valid/ready        req_type, item_cost, start_pos, budget
//  o_rsp     out   valid/ready        affordable_count
//  i_cfg     in    i_cfg_we           i_cfg_wdata (item_count)
//
//  A load writes the prefix sum memory directly.
//  A query runs S search steps (up to 15 for 16384 items): each step is one
//  read of the single memory port and a compare.
//  A finished count waits in the output register; the next word is accepted
//  meanwhile, and a query only stalls at its end while that register is full.
//  Reset clears control state and sets item_count to 16384; memory is not
//  cleared.
// ----------------------------------------------------------------------------
module circular_budget_prefix_search #(
    parameter int MAX_ITEMS = cbps_pkg::MAX_ITEMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cbps_pkg::COUNT_W-1:0]    i_cfg_wdata,
    cbps_req_if.sink                        i_req,
    cbps_rsp_if.source                      o_rsp
);

    localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW   = $clog2(MAX_ITEMS + 1);
    localparam int CMPW = (NW > cbps_pkg::COUNT_W) ? NW : cbps_pkg::COUNT_W;
    localparam int SW   = cbps_pkg::SUM_W;
    localparam int LW   = cbps_pkg::BUDGET_W + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PA    = 6'b000010,
        S_TOT   = 6'b000100,
        S_CMP   = 6'b001000,
        S_ISSUE = 6'b010000,
        S_TEST  = 6'b100000
    } t_state;

    t_state                             r_state, n_state;
    logic [cbps_pkg::COUNT_W-1:0]       r_item_count;
    logic [AW-1:0]                      r_ptr, n_ptr;
    logic [SW-1:0]                      r_total, n_total;
    logic [cbps_pkg::POS_W-1:0]         r_s, n_s;
    logic [cbps_pkg::BUDGET_W-1:0]      r_budget, n_budget;
    logic [NW-1:0]                      r_a, n_a;
    logic [SW-1:0]                      r_pa, n_pa;
    logic [LW-1:0]                      r_lim, n_lim;
    logic [NW-1:0]                      r_lo, n_lo;
    logic [NW-1:0]                      r_hi, n_hi;
    logic [NW-1:0]                      r_mid, n_mid;
    logic                               r_wrap, n_wrap;
    logic                               r_out_valid, n_out_valid;
    logic [cbps_pkg::COUNT_W-1:0]       r_out_cnt, n_out_cnt;

    logic [SW-1:0]                      r_mem [MAX_ITEMS];
    logic [SW-1:0]                      r_rdata;
    logic [AW-1:0]                      mem_raddr;
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic [SW-1:0]                      mem_wdata;

    logic [CMPW-1:0]                    cnt_ext;
    logic [CMPW-1:0]                    s_ext;
    logic [NW-1:0]                      n_items;
    logic [NW-1:0]                      load_p;
    logic [NW-1:0]                      load_p1;
    logic [SW:0]                        load_sum;
    logic [NW:0]                        span;
    logic [NW-1:0]                      mid;
    logic [NW-1:0]                      mid_m1;
    logic [NW-1:0]                      s_m1;
    logic [NW-1:0]                      s_m2;
    logic [NW-1:0]                      n_m1;
    logic [LW-1:0]                      pa_budget;
    logic [NW-1:0]                      k;
    logic [CMPW-1:0]                    k_ext;
    logic                               accept;

    assign accept = i_req.valid && i_req.ready;

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.affordable_count = r_out_cnt;

    // clamp item_count to [1, MAX_ITEMS]
    assign cnt_ext = CMPW'(r_item_count);
    assign n_items = (cnt_ext == '0) ? NW'(1) :
                     (cnt_ext > CMPW'(MAX_ITEMS)) ? NW'(MAX_ITEMS) : cnt_ext[NW-1:0];
    assign s_ext   = CMPW'(r_s);

    assign load_p   = (NW'(r_ptr) >= n_items) ? '0 : NW'(r_ptr);
    assign load_p1  = load_p + NW'(1);
    assign load_sum = ((load_p == '0) ? (SW+1)'(0) : {1'b0, r_total})
                      + (SW+1)'(i_req.item_cost);

    assign span      = {1'b0, r_hi} - {1'b0, r_lo} + (NW+1)'(1);
    assign mid       = r_lo + span[NW:1];
    assign mid_m1    = mid - NW'(1);
    assign s_m1      = s_ext[NW-1:0] - NW'(1);
    assign s_m2      = s_ext[NW-1:0] - NW'(2);
    assign n_m1      = n_items - NW'(1);
    assign pa_budget = LW'(r_pa) + LW'(r_budget);

    assign k     = r_wrap ? (n_items - r_a + r_lo) : (r_lo - r_a);
    assign k_ext = CMPW'(k);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_s         = r_s;
        n_budget    = r_budget;
        n_a         = r_a;
        n_pa        = r_pa;
        n_lim       = r_lim;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_wrap      = r_wrap;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_cnt   = r_out_cnt;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = load_p[AW-1:0];
        mem_wdata   = load_sum[SW] ? cbps_pkg::SUM_MAX : load_sum[SW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == cbps_pkg::REQ_LOAD) begin
                        mem_we  = 1'b1;
                        n_total = mem_wdata;
                        n_ptr   = (load_p1 >= n_items) ? '0 : load_p1[AW-1:0];
                    end else begin
                        n_s      = i_req.start_pos;
                        n_budget = i_req.budget;
                        n_state  = S_PA;
                    end
                end
            end
            S_PA: begin
                if (s_ext == '0 || s_ext > CMPW'(n_items)) begin
                    n_a     = '0;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_wrap  = 1'b0;
                    n_state = S_ISSUE;
                end else begin
                    n_a       = s_m1;
                    mem_raddr = s_m2[AW-1:0];
                    n_state   = S_TOT;
                end
            end
            S_TOT: begin
                mem_raddr = n_m1[AW-1:0];
                n_pa      = (r_a == '0) ? '0 : r_rdata;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (LW'(r_rdata) <= pa_budget) begin
                    n_wrap = 1'b1;
                    n_lim  = pa_budget - LW'(r_rdata);
                    n_lo   = '0;
                    n_hi   = r_a;
                end else begin
                    n_wrap = 1'b0;
                    n_lim  = pa_budget;
                    n_lo   = r_a;
                    n_hi   = n_items;
                end
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (r_lo < r_hi) begin
                    mem_raddr = mid_m1[AW-1:0];
                    n_mid     = mid;
                    n_state   = S_TEST;
                end else if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = k_ext[cbps_pkg::COUNT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            S_TEST: begin
                if (LW'(r_rdata) <= r_lim) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid - NW'(1);
                end
                n_state = S_ISSUE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_item_count <= cbps_pkg::ITEM_COUNT_RST;
            r_ptr        <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_item_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_budget  <= n_budget;
        r_a       <= n_a;
        r_pa      <= n_pa;
        r_lim     <= n_lim;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_wrap    <= n_wrap;
        r_out_cnt <= n_out_cnt;
    end

endmodule
